/* rtl/core/fccm_pkg.sv */
`timescale 1ns / 1ps

package fccm_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 4096;
    localparam int IDX_W         = 12;   // entry index width
    localparam int CNT_W         = 13;   // counts up to TABLE_ENTRIES
    localparam int LINK_W        = 16;

    localparam logic [LINK_W-1:0] LINK_FREE = 16'h0000;
    localparam logic [LINK_W-1:0] LINK_END  = 16'hFFFF;

    localparam logic [CNT_W-1:0] FIRST_CLUSTER = 13'd2;  // 0 and 1 are reserved

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_READ  = 2'd1,
        OP_ALLOC = 2'd2,
        OP_FREE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_RANGE    = 2'd2,
        ST_TOO_LONG = 2'd3
    } t_status;

endpackage

/* rtl/core/fat_cluster_chain_manager_unit.sv */
`timescale 1ns / 1ps

// FAT16-style cluster link table, 4096 x 16 bit, one block RAM.
// Command channel: start/busy with operation, cluster, entry_value and
// cluster_request; a word is taken on a clock edge with start high and busy low.
// Result channel: o_result_strobe marks one cycle carrying o_result_value and
// o_status. The receiver cannot stall; every word must be taken when shown.
// The result shows in the first cycle with busy low after the command, and a
// new command can be taken in that same cycle.
// How each command is served by the single RAM read port walking the table:
//   load              written at once
//   read              one registered RAM read
//   allocate (n > 0)  a count pass, then a link pass and the chain end, each
//                     pass scanning the table positions in order, one entry
//                     per cycle; the count pass stops early once enough are free
//   allocate (n = 0)  no scan; the end marker is returned
//   free              walks the chain, zeroing each link
// Configuration: i_cfg_wr_en/i_cfg_wr_data write cluster_count;
// write only while idle. Reset value 4096.
// Reset: a clearing pass writes zero to every entry, one per cycle, with busy
// high; config writes are still taken during it.

module fat_cluster_chain_manager_unit
    import fccm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_operation,
    input  logic [IDX_W-1:0]    i_cluster,
    input  logic [LINK_W-1:0]   i_entry_value,
    input  logic [CNT_W-1:0]    i_cluster_request,
    input  logic                i_cfg_wr_en,
    input  logic [CNT_W-1:0]    i_cfg_wr_data,
    output logic                o_result_strobe,
    output logic [LINK_W-1:0]   o_result_value,
    output logic [1:0]          o_status
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_COUNT,   // pass 1: count free entries until request is met
        S_LINK,    // pass 2: link free entries in ascending order
        S_TAIL,    // terminate chain with end marker
        S_FCHK,    // free walk: check current link, issue read
        S_FWR      // free walk: zero the entry, step to next
    } t_state;

    // Link table RAM, read data registered
    logic [LINK_W-1:0] r_mem [TABLE_ENTRIES];
    logic [LINK_W-1:0] r_rd_data;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [LINK_W-1:0] mem_wd;
    logic [IDX_W-1:0]  mem_ra;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cluster_count;
    logic [CNT_W-1:0]  r_scan, n_scan;        // next address to read / clear
    logic              r_pend, n_pend;        // read in flight during a scan
    logic [IDX_W-1:0]  r_pend_addr, n_pend_addr;
    logic [CNT_W-1:0]  r_count, n_count;      // free seen / remaining / freed
    logic [CNT_W-1:0]  r_want, n_want;
    logic [IDX_W-1:0]  r_prev, n_prev;
    logic [IDX_W-1:0]  r_first, n_first;
    logic              r_have, n_have;
    logic [LINK_W-1:0] r_cur, n_cur;
    logic              r_strobe, n_strobe;
    logic [LINK_W-1:0] r_value, n_value;
    t_status           r_status, n_status;

    logic [CNT_W-1:0]  limit;
    logic              cmd_in_range;
    logic              scan_issue;
    logic              scan_hit;

    assign limit = (r_cluster_count > CNT_W'(TABLE_ENTRIES))
                 ? CNT_W'(TABLE_ENTRIES) : r_cluster_count;
    assign cmd_in_range = {1'b0, i_cluster} < limit;
    assign scan_issue   = r_scan < limit;
    assign scan_hit     = r_pend && (r_rd_data == LINK_FREE);

    assign busy            = (r_state != S_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_result_value  = r_value;
    assign o_status        = r_status;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    always_comb begin
        n_state     = r_state;
        n_scan      = r_scan;
        n_pend      = 1'b0;
        n_pend_addr = r_pend_addr;
        n_count     = r_count;
        n_want      = r_want;
        n_prev      = r_prev;
        n_first     = r_first;
        n_have      = r_have;
        n_cur       = r_cur;
        n_strobe    = 1'b0;
        n_value     = r_value;
        n_status    = r_status;
        mem_we      = 1'b0;
        mem_wa      = r_scan[IDX_W-1:0];
        mem_wd      = LINK_FREE;
        mem_ra      = i_cluster;

        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_scan = r_scan + 1'b1;
                if (r_scan == CNT_W'(TABLE_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    case (t_op'(i_operation))
                        OP_LOAD: begin
                            n_strobe = 1'b1;
                            if (cmd_in_range) begin
                                mem_we   = 1'b1;
                                mem_wa   = i_cluster;
                                mem_wd   = i_entry_value;
                                n_value  = i_entry_value;
                                n_status = ST_OK;
                            end else begin
                                n_value  = LINK_FREE;
                                n_status = ST_RANGE;
                            end
                        end
                        OP_READ: begin
                            if (cmd_in_range) begin
                                n_state = S_READ;
                            end else begin
                                n_strobe = 1'b1;
                                n_value  = LINK_FREE;
                                n_status = ST_RANGE;
                            end
                        end
                        OP_ALLOC: begin
                            if (i_cluster_request == '0) begin
                                n_strobe = 1'b1;
                                n_value  = LINK_END;
                                n_status = ST_OK;
                            end else begin
                                n_state = S_COUNT;
                                n_want  = i_cluster_request;
                                n_count = '0;
                                n_scan  = FIRST_CLUSTER;
                            end
                        end
                        default: begin
                            n_state = S_FCHK;
                            n_cur   = {4'b0, i_cluster};
                            n_count = '0;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
                n_value  = r_rd_data;
                n_status = ST_OK;
            end
            S_COUNT: begin
                mem_ra = r_scan[IDX_W-1:0];
                if (scan_issue) begin
                    n_pend      = 1'b1;
                    n_pend_addr = r_scan[IDX_W-1:0];
                    n_scan      = r_scan + 1'b1;
                end
                if (scan_hit && (r_count + 1'b1 == r_want)) begin
                    // enough free entries: restart scan for linking
                    n_state = S_LINK;
                    n_pend  = 1'b0;
                    n_scan  = FIRST_CLUSTER;
                    n_count = r_want;
                    n_have  = 1'b0;
                end else if (scan_hit) begin
                    n_count = r_count + 1'b1;
                end else if (!r_pend && !scan_issue) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    n_value  = LINK_FREE;
                    n_status = ST_NO_SPACE;
                end
            end
            S_LINK: begin
                mem_ra = r_scan[IDX_W-1:0];
                if (scan_issue) begin
                    n_pend      = 1'b1;
                    n_pend_addr = r_scan[IDX_W-1:0];
                    n_scan      = r_scan + 1'b1;
                end
                if (scan_hit) begin
                    // previous entry is already behind the read pointer
                    if (r_have) begin
                        mem_we = 1'b1;
                        mem_wa = r_prev;
                        mem_wd = {4'b0, r_pend_addr};
                    end else begin
                        n_first = r_pend_addr;
                    end
                    n_have  = 1'b1;
                    n_prev  = r_pend_addr;
                    n_count = r_count - 1'b1;
                    if (r_count == CNT_W'(1)) begin
                        n_state = S_TAIL;
                        n_pend  = 1'b0;
                    end
                end
            end
            S_TAIL: begin
                mem_we   = 1'b1;
                mem_wa   = r_prev;
                mem_wd   = LINK_END;
                n_state  = S_IDLE;
                n_strobe = 1'b1;
                n_value  = {4'b0, r_first};
                n_status = ST_OK;
            end
            S_FCHK: begin
                mem_ra = r_cur[IDX_W-1:0];
                if (r_cur == LINK_END) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    n_value  = {3'b0, r_count};
                    n_status = ST_OK;
                end else if ((r_cur < {3'b0, FIRST_CLUSTER}) || (r_cur >= {3'b0, limit})) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    n_value  = {3'b0, r_count};
                    n_status = ST_RANGE;
                end else if (r_count >= limit) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    n_value  = {3'b0, r_count};
                    n_status = ST_TOO_LONG;
                end else begin
                    n_state = S_FWR;
                end
            end
            S_FWR: begin
                // write lands before the next read is issued in S_FCHK
                mem_we  = 1'b1;
                mem_wa  = r_cur[IDX_W-1:0];
                mem_wd  = LINK_FREE;
                n_count = r_count + 1'b1;
                n_cur   = r_rd_data;
                n_state = S_FCHK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_scan          <= '0;
            r_pend          <= 1'b0;
            r_strobe        <= 1'b0;
            r_cluster_count <= CNT_W'(TABLE_ENTRIES);
        end else begin
            r_state  <= n_state;
            r_scan   <= n_scan;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
            if (i_cfg_wr_en) begin
                r_cluster_count <= i_cfg_wr_data;
            end
        end
        r_pend_addr <= n_pend_addr;
        r_count     <= n_count;
        r_want      <= n_want;
        r_prev      <= n_prev;
        r_first     <= n_first;
        r_have      <= n_have;
        r_cur       <= n_cur;
        r_value     <= n_value;
        r_status    <= n_status;
    end

endmodule

/* rtl/core/fccm_checker.sv */
`timescale 1ns / 1ps

module fccm_checker
    import fccm_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_result_strobe,
    input logic [LINK_W-1:0] o_result_value,
    input logic [1:0]        o_status
);

    // no result word unless a command was taken or the block was working
    a_no_spurious_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!start && !busy) |=> !o_result_strobe)
        else $error("result strobe without a command");

    // result only shows once the block has gone idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> !busy)
        else $error("result strobe while busy");

    // an accepted command holds busy or answers at once
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_result_strobe))
        else $error("command accepted without effect");

    // failed allocation returns zero
    a_no_space_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && (o_status == ST_NO_SPACE)) |-> (o_result_value == LINK_FREE))
        else $error("no-space result carries a value");

endmodule

bind fat_cluster_chain_manager_unit fccm_checker u_fccm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_strobe (o_result_strobe),
    .o_result_value  (o_result_value),
    .o_status        (o_status)
);
